// File: hdl/sle_pkg.sv
// ---------------------------------------------------------------------------
// sle_pkg - shared constants for the serial line editor
// Character codes, echo script codes and the echo script table.
// ---------------------------------------------------------------------------
package sle_pkg;

    // Default number of line buffer slots (one spare slot past the longest line)
    localparam int LINE_SLOTS_DEF = 21;

    // Character codes
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    // Request kinds on the input tuser
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_DONE = 1'b1;

    // Result kinds on the output tuser
    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    // Echo scripts
    typedef logic [1:0] script_t;
    localparam script_t SCR_CHAR   = 2'd0;  // the received character
    localparam script_t SCR_ERASE  = 2'd1;  // BS, space, BS
    localparam script_t SCR_NL     = 2'd2;  // LF, CR, then the line follows
    localparam script_t SCR_PROMPT = 2'd3;  // LF, CR, '>', '>', space

    typedef logic [2:0] step_t;

    // Index of the final step of a script
    function automatic step_t script_last(input script_t scr);
        step_t last;
        case (scr)
            SCR_CHAR:   last = 3'd0;
            SCR_ERASE:  last = 3'd2;
            SCR_NL:     last = 3'd1;
            SCR_PROMPT: last = 3'd4;
            default:    last = 3'd0;
        endcase
        return last;
    endfunction

    // Byte produced at a given step of a script
    function automatic logic [7:0] script_byte(input script_t scr, input step_t step,
                                               input logic [7:0] ch);
        logic [7:0] b;
        case (scr)
            SCR_CHAR:  b = ch;
            SCR_ERASE: b = (step == 3'd1) ? CH_SPACE : CH_BS;
            default:
            begin
                case (step)
                    3'd0:    b = CH_LF;
                    3'd1:    b = CH_CR;
                    3'd2:    b = CH_GT;
                    3'd3:    b = CH_GT;
                    default: b = CH_SPACE;
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

// File: hdl/sle_ram.sv
// ---------------------------------------------------------------------------
// sle_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/serial_line_editor.sv
// ---------------------------------------------------------------------------
// serial_line_editor - terminal line editor with echo
// Collects received bytes into a line, echoes them and hands finished lines
// to the command side, one character per output word.
// ---------------------------------------------------------------------------
// Each input word is taken while the sequencer is idle. Its
// results then leave through the output register at one word per cycle when
// the sink is ready: a printable byte gives one word, an erase three, an empty
// line end or a done event five, and a line end with n characters 2 + n words
// (up to LINE_SLOTS + 1). The sequencer is busy until its last word is loaded
// into the output register, the line stream being read from the line buffer
// RAM one slot per cycle when the sink is ready. Words that cause no result
// leave the sequencer idle. There is no clearing pass.
// ---------------------------------------------------------------------------
module serial_line_editor
    import sle_pkg::*;
#(
    parameter int LINE_SLOTS = LINE_SLOTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    input  logic       s_axis_tuser,   // [0] req_type
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] out_kind
    output logic       m_axis_tlast
);

    localparam int CW = $clog2(LINE_SLOTS);
    localparam logic [CW-1:0] COUNT_MAX = CW'(LINE_SLOTS - 1);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ECHO = 2'd1;
    localparam logic [1:0] ST_LINE = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic          waiting_reg, waiting_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] idx_reg, idx_next;
    script_t       scr_reg, scr_next;
    step_t         step_reg, step_next;
    logic [7:0]    ch_reg, ch_next;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          out_kind_reg, out_kind_next;
    logic          out_last_reg, out_last_next;

    logic          accept;
    logic          slot_free;
    logic          wr_en;
    logic          rd_en;
    logic [CW-1:0] rd_addr;
    logic [6:0]    rd_data;
    logic          is_print;
    logic          is_eol;
    logic          is_erase;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !out_valid_reg || m_axis_tready;

    assign is_eol   = (s_axis_tdata == CH_CR) || (s_axis_tdata == CH_LF);
    assign is_erase = (s_axis_tdata == CH_BS) || (s_axis_tdata == CH_DEL);
    assign is_print = (s_axis_tdata >= CH_SPACE) && (s_axis_tdata <= CH_TILDE);

    // Store a printable byte at the current count
    assign wr_en = accept && !waiting_reg && (s_axis_tuser == REQ_BYTE) && is_print;

    // Prefetch slot 0 on accept, then the next slot with each line word
    assign rd_en   = accept || ((state_reg == ST_LINE) && slot_free);
    assign rd_addr = accept ? '0 : idx_reg + CW'(1);

    sle_ram #(
        .WIDTH (7),
        .DEPTH (LINE_SLOTS)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg),
        .wr_data (s_axis_tdata[6:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Decode words and step through echo scripts and line streams
    always_comb
    begin
        state_next     = state_reg;
        waiting_next   = waiting_reg;
        count_next     = count_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        scr_next       = scr_reg;
        step_next      = step_reg;
        ch_next        = ch_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_byte_next  = out_byte_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ch_next   = s_axis_tdata;
                    step_next = '0;
                    if (waiting_reg)
                    begin
                        if (s_axis_tuser == REQ_DONE)
                        begin
                            scr_next     = SCR_PROMPT;
                            waiting_next = 1'b0;
                            state_next   = ST_ECHO;
                        end
                    end
                    else if (s_axis_tuser == REQ_BYTE)
                    begin
                        if (is_eol)
                        begin
                            state_next = ST_ECHO;
                            if (count_reg != '0)
                            begin
                                scr_next     = SCR_NL;
                                len_next     = count_reg;
                                count_next   = '0;
                                waiting_next = 1'b1;
                            end
                            else
                            begin
                                scr_next = SCR_PROMPT;
                            end
                        end
                        else if (is_erase)
                        begin
                            if (count_reg != '0)
                            begin
                                scr_next   = SCR_ERASE;
                                count_next = count_reg - CW'(1);
                                state_next = ST_ECHO;
                            end
                        end
                        else if (is_print)
                        begin
                            scr_next   = SCR_CHAR;
                            state_next = ST_ECHO;
                            if (count_reg != COUNT_MAX)
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                    end
                end
            end

            ST_ECHO:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ECHO;
                    out_byte_next  = script_byte(scr_reg, step_reg, ch_reg);
                    out_last_next  = 1'b0;
                    step_next      = step_reg + 3'd1;
                    if (step_reg == script_last(scr_reg))
                    begin
                        if (scr_reg == SCR_NL)
                        begin
                            idx_next   = '0;
                            state_next = ST_LINE;
                        end
                        else
                        begin
                            out_last_next = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                end
            end

            ST_LINE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_LINE;
                    out_byte_next  = {1'b0, rd_data};
                    out_last_next  = (idx_reg == len_reg - CW'(1));
                    idx_next       = idx_reg + CW'(1);
                    if (idx_reg == len_reg - CW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            waiting_reg   <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            waiting_reg   <= waiting_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and sequencing registers
    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        idx_reg      <= idx_next;
        scr_reg      <= scr_next;
        step_reg     <= step_next;
        ch_reg       <= ch_next;
        out_byte_reg <= out_byte_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
